@@ rtl/chist_pkg.sv @@
// Shared types and constants for the clamped uniform histogram.
package chist_pkg;

   // Action codes carried by an input word
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Fixed field widths
   localparam int SAMPLE_BITS = 32;
   localparam int SCALE_BITS  = 32;
   localparam int NBINS_BITS  = 7;
   localparam int BIN_NUM_BITS = 6;
   localparam int OUT_COUNT_BITS = 32;

   // Configuration register indexes
   localparam logic [1:0] CSR_RANGE_MIN   = 2'd0;
   localparam logic [1:0] CSR_BIN_SCALE   = 2'd1;
   localparam logic [1:0] CSR_BINS_IN_USE = 2'd2;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // One queued command: for add the clamped bin, for read-out the last bin
   typedef struct packed {
      logic [1:0]            action;
      logic [NBINS_BITS-1:0] sel;
   } cmd_type;

   // Status from the back end to the top level
   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

@@ rtl/chist_if.sv @@
// Handshake interfaces for the sample and read-out channels.
interface chist_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic signed [31:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

interface chist_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  bin_number;
   logic [31:0] bin_count;
   logic        last_bin;

   modport source (output valid, output bin_number, output bin_count, output last_bin,
                   input ready);
   modport sink   (input valid, input bin_number, input bin_count, input last_bin,
                   output ready);
endinterface

@@ rtl/clamped_uniform_histogram_core.sv @@
// Top level of the clamped uniform histogram: registers, front, queue, back.
//
//  channel  dir  words                          handshake
//  req      in   action, sample                 valid/ready
//  rsp      out  bin_number, bin_count, last_bin valid/ready
//  csr      in   csr_index, csr_wdata           csr_we, no back-pressure
//
// An add in the back end is a RAM read, then a write; the front pipeline
// registers each word in s1 and s2, and the 4-entry queue decouples the two.
// A read-out reads each bin from RAM (registered read) before loading its word.
// A clear sweeps all MAX_BINS counters, one a cycle.
// After reset the same sweep runs with req.ready low.
// rsp stalls hold the back end only; the front keeps filling the queue.
module clamped_uniform_histogram_core #(
   parameter int MAX_BINS   = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   chist_req_if.sink   req,
   chist_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [31:0] range_min_ff;
   logic [31:0]        bin_scale_ff;
   logic [chist_pkg::NBINS_BITS-1:0] bins_in_use_ff;
   logic [chist_pkg::NBINS_BITS-1:0] last_sel;

   logic               push;
   chist_pkg::cmd_type push_data;
   logic               q_full;
   logic               q_valid;
   logic               pop;
   chist_pkg::cmd_type q_head;
   chist_pkg::back_status_type back_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff   <= '0;
         bin_scale_ff   <= 32'd65536;
         bins_in_use_ff <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            chist_pkg::CSR_RANGE_MIN:   range_min_ff   <= csr_wdata;
            chist_pkg::CSR_BIN_SCALE:   bin_scale_ff   <= csr_wdata;
            chist_pkg::CSR_BINS_IN_USE: bins_in_use_ff <= csr_wdata[chist_pkg::NBINS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // highest bin in use, with bins_in_use clamped to 1 .. MAX_BINS
   always_comb begin
      if (bins_in_use_ff == '0) begin
         last_sel = '0;
      end else if (32'(bins_in_use_ff) > MAX_BINS) begin
         last_sel = chist_pkg::NBINS_BITS'(MAX_BINS - 1);
      end else begin
         last_sel = bins_in_use_ff - 1'b1;
      end
   end

   chist_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .hold      (back_status.init_busy),
      .range_min (range_min_ff),
      .bin_scale (bin_scale_ff),
      .last_sel  (last_sel),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   chist_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   chist_back #(.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_head (q_head),
      .pop    (pop),
      .rsp    (rsp),
      .status (back_status)
   );

endmodule

@@ rtl/chist_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module chist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/chist_fifo.sv @@
// Short command queue between the front end and the back end.
module chist_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  chist_pkg::cmd_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output chist_pkg::cmd_type  head
);

   chist_pkg::cmd_type                  slot_ff [chist_pkg::QUEUE_DEPTH];
   logic [chist_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [chist_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [chist_pkg::QPTR_BITS:0]       count_ff, count_in;

   assign full      = (count_ff == (chist_pkg::QPTR_BITS + 1)'(chist_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage: payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/chist_front.sv @@
// Front end: takes input words, maps samples to clamped bins, queues commands.
module chist_front (
   input  logic               clock,
   input  logic               reset,
   chist_req_if.sink          req,
   input  logic               hold,
   input  logic signed [31:0] range_min,
   input  logic [31:0]        bin_scale,
   input  logic [chist_pkg::NBINS_BITS-1:0] last_sel,
   output logic               push,
   output chist_pkg::cmd_type push_data,
   input  logic               q_full
);

   // stage 1: difference to the lower edge
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_action_ff;
   logic signed [32:0]    s1_diff_ff;
   logic [chist_pkg::NBINS_BITS-1:0] s1_last_ff;

   // stage 2: integer part of diff * scale
   logic                  s2_valid_ff, s2_valid_in;
   logic [1:0]            s2_action_ff;
   logic                  s2_nonpos_ff;
   logic [31:0]           s2_prod_hi_ff;
   logic [chist_pkg::NBINS_BITS-1:0] s2_last_ff;

   logic                  s2_needs_push;
   logic                  advance;
   logic                  take;
   logic [63:0]           product;

   assign s2_needs_push = s2_valid_ff && (s2_action_ff != chist_pkg::ACT_NONE);
   assign advance       = !(s2_needs_push && q_full);
   assign req.ready     = advance && !hold;
   assign take          = req.valid && req.ready;

   assign product = 64'(s1_diff_ff[31:0]) * 64'(bin_scale);

   always_comb begin
      s1_valid_in = advance ? take : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_action_ff  <= req.action;
         s1_diff_ff    <= 33'(req.sample) - 33'(range_min);
         s1_last_ff    <= last_sel;
         s2_action_ff  <= s1_action_ff;
         s2_nonpos_ff  <= s1_diff_ff[32] || (s1_diff_ff == '0);
         s2_prod_hi_ff <= product[63:32];
         s2_last_ff    <= s1_last_ff;
      end
   end

   // clamp to the bins in use and form the command
   always_comb begin
      push_data.action = s2_action_ff;
      if (s2_action_ff == chist_pkg::ACT_READ) begin
         push_data.sel = s2_last_ff;
      end else if (s2_nonpos_ff) begin
         push_data.sel = '0;
      end else if (s2_prod_hi_ff > 32'(s2_last_ff)) begin
         push_data.sel = s2_last_ff;
      end else begin
         push_data.sel = s2_prod_hi_ff[chist_pkg::NBINS_BITS-1:0];
      end
   end

   assign push = s2_needs_push && !q_full;

endmodule

@@ rtl/chist_back.sv @@
// Back end: clears, increments and reads out the bin counters in RAM.
module chist_back #(
   parameter int MAX_BINS   = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  chist_pkg::cmd_type     q_head,
   output logic                   pop,
   chist_rsp_if.source            rsp,
   output chist_pkg::back_status_type status
);

   localparam int IDX_BITS = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_ADDR = IDX_BITS'(MAX_BINS - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CLEAR   = 3'd1;
   localparam logic [2:0] S_ADD_WR  = 3'd2;
   localparam logic [2:0] S_RO_RD   = 3'd3;
   localparam logic [2:0] S_RO_LOAD = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   last_ff, last_in;
   logic                  init_ff, init_in;
   logic                  out_valid_ff, out_valid_in;
   logic [chist_pkg::BIN_NUM_BITS-1:0] out_num_ff;
   logic [chist_pkg::OUT_COUNT_BITS-1:0] out_count_ff;
   logic                  out_last_ff;
   logic                  load_out;
   logic                  out_free;

   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [IDX_BITS-1:0]   ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [chist_pkg::OUT_COUNT_BITS-1:0] count_sat;

   chist_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // clip a wide count to the 32-bit output field
   generate
      if (COUNT_BITS > chist_pkg::OUT_COUNT_BITS) begin : g_wide
         assign count_sat = (ram_rdata[COUNT_BITS-1:chist_pkg::OUT_COUNT_BITS] != '0)
                            ? '1 : ram_rdata[chist_pkg::OUT_COUNT_BITS-1:0];
      end else begin : g_narrow
         assign count_sat = chist_pkg::OUT_COUNT_BITS'(ram_rdata);
      end
   endgenerate

   assign out_free = !out_valid_ff || rsp.ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      init_in   = init_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cnt_ff;
      load_out  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               case (q_head.action)
                  chist_pkg::ACT_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  chist_pkg::ACT_ADD: begin
                     ram_re    = 1'b1;
                     ram_raddr = IDX_BITS'(q_head.sel);
                     cnt_in    = IDX_BITS'(q_head.sel);
                     state_in  = S_ADD_WR;
                  end
                  chist_pkg::ACT_READ: begin
                     cnt_in   = '0;
                     last_in  = IDX_BITS'(q_head.sel);
                     state_in = S_RO_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            ram_we = 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               init_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ADD_WR: begin
            // saturating increment of the count just read
            ram_we    = 1'b1;
            ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
            state_in  = S_IDLE;
         end
         S_RO_RD: begin
            ram_re   = 1'b1;
            state_in = S_RO_LOAD;
         end
         S_RO_LOAD: begin
            if (out_free) begin
               load_out = 1'b1;
               if (cnt_ff == last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_RO_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state; reset starts a clearing pass over the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output register and read-out bound: payload only
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (load_out) begin
         out_num_ff   <= chist_pkg::BIN_NUM_BITS'(cnt_ff);
         out_count_ff <= count_sat;
         out_last_ff  <= (cnt_ff == last_ff);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.bin_number = out_num_ff;
   assign rsp.bin_count  = out_count_ff;
   assign rsp.last_bin   = out_last_ff;
   assign status.init_busy = init_ff;

   // a write-back always follows its own read
   a_add_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_WR) |-> ($past(state_ff) == S_IDLE && $past(ram_re)))
      else $error("increment write without a preceding read");

   // no command is taken while a pass or an operation is in progress
   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == S_IDLE))
      else $error("command popped while busy");

   // a read-out word is loaded only after its RAM read
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (state_ff == S_RO_LOAD && $past(state_ff) != S_IDLE))
      else $error("read-out word loaded without RAM read");

   // the marked word ends the read-out run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load_out && cnt_ff == last_ff) |=> (state_ff == S_IDLE))
      else $error("read-out continued past the last bin");

endmodule
